@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the point locator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/rcb_pkg.sv @@
// ----------------------------------------------------------------------------
// rcb_pkg
// Types and constants shared by the tiling point locator modules.
// ----------------------------------------------------------------------------
package rcb_pkg;

	localparam int COORD_W       = 32;
	localparam int MAX_CELLS_DEF = 64;
	localparam int CFG_IDX_W     = 3;
	localparam int CNT_REG_W     = 7;
	localparam int IDX_OUT_W     = 6;

	localparam logic OP_BUILD  = 1'b0;
	localparam logic OP_LOCATE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5,
		REG_COUNT = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic                      op;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} item_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0]      cell_index;
		logic                      found;
		logic signed [COORD_W-1:0] lo_x;
		logic signed [COORD_W-1:0] lo_y;
		logic signed [COORD_W-1:0] lo_z;
		logic signed [COORD_W-1:0] hi_x;
		logic signed [COORD_W-1:0] hi_y;
		logic signed [COORD_W-1:0] hi_z;
		logic                      last;
	} result_t;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] lo;
		logic [2:0][COORD_W-1:0] hi;
	} box_t;

endpackage

@@ rtl/core/rcb_cell_mem.sv @@
// ----------------------------------------------------------------------------
// rcb_cell_mem
// Cell box storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rcb_cell_mem import rcb_pkg::*; #(
	parameter int DEPTH = MAX_CELLS_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  box_t          wdata,
	input  logic [AW-1:0] raddr,
	output box_t          rdata
);

	box_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/rcb_mul.sv @@
// ----------------------------------------------------------------------------
// rcb_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module rcb_mul import rcb_pkg::*; #(
	parameter int W = COORD_W + 1
) (
	input  logic           clk,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= {{W{1'b0}}, a} * {{W{1'b0}}, b};
	end

endmodule

@@ rtl/core/rcb_tiling_point_locator_core.sv @@
// Locate: one stored cell read per cycle from the cell memory.
// Build: per split, a volume scan over every existing cell on the shared multiplier, then
// the cells above the split cell move up one slot; after the last split each cell is emitted.
// One item is in work at a time; the next item is taken once its results are queued.
// Reset clears registers, the cell count and the state; cell memory is not cleared.
// ----------------------------------------------------------------------------
// rcb_tiling_point_locator_core
// Bisection tiling of a 3-D box and first-match point location over the cells.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcb_tiling_point_locator_core import rcb_pkg::*; #(
	parameter int MAX_CELLS = MAX_CELLS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result
);

	localparam int MW   = COORD_W + 1;
	localparam int PW   = 2 * MW;
	localparam int AW3  = 3 * MW;
	localparam int VW   = AW3 + 1;
	localparam int AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int CNTW = $clog2(MAX_CELLS + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_INIT, S_CHK, S_VRD, S_VEXT, S_M1, S_M2, S_M3, S_M4, S_SGN, S_VCMP,
		S_SRD, S_SPL, S_SHR, S_SHW, S_WLO, S_WHI, S_ERD, S_EOUT,
		S_LRD, S_LCMP, S_LOUT, S_NF
	} state_t;

	state_t state_q;

	logic [2:0][COORD_W-1:0] wmin_q;
	logic [2:0][COORD_W-1:0] wmax_q;
	logic [CNT_REG_W-1:0]    count_q;

	logic [CNTW-1:0] n_q, k_q, built_q, i_q, j_q, best_q;
	logic [2:0][COORD_W-1:0] pt_q;
	logic [2:0][MW-1:0] mag_q;
	logic               neg_q;
	logic [MW-1:0]      ph_q;
	logic [AW3-1:0]     acc_q;
	logic [VW-1:0]      vol_q, best_vol_q;
	box_t               lowbox_q, highbox_q, box_q;
	logic               res_valid_q;
	result_t            result_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	box_t          mem_wdata, rd;
	logic [MW-1:0] mul_a, mul_b;
	logic [PW-1:0] prod;

	logic [2:0][MW-1:0] ext, mag;
	logic [1:0]         axis;
	logic [MW-1:0]      msum;
	logic [COORD_W-1:0] mid;
	box_t               lo_half, hi_half;
	logic               hit, room, res_load;
	logic [8:0]         count_ext;
	logic [CNTW-1:0]    k_sat, i_nxt, best_nxt;

	rcb_cell_mem #(.DEPTH(MAX_CELLS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd)
	);

	rcb_mul #(.W(MW)) u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign result       = result_q;
	assign room         = !res_valid_q || !result_stall;
	assign res_load     = room && (state_q == S_EOUT || state_q == S_LOUT || state_q == S_NF);

	assign count_ext = {2'b00, count_q};
	assign k_sat     = (count_ext > 9'(MAX_CELLS)) ? CNTW'(MAX_CELLS) : CNTW'(count_q);
	assign i_nxt     = CNTW'(i_q + 1'b1);
	assign best_nxt  = CNTW'(best_q + 1'b1);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			ext[a] = {rd.hi[a][COORD_W-1], rd.hi[a]} - {rd.lo[a][COORD_W-1], rd.lo[a]};
			mag[a] = ext[a][MW-1] ? (~ext[a] + 1'b1) : ext[a];
		end
		if ($signed(ext[0]) >= $signed(ext[1]) && $signed(ext[0]) >= $signed(ext[2])) begin
			axis = 2'd0;
		end else if ($signed(ext[1]) >= $signed(ext[2])) begin
			axis = 2'd1;
		end else begin
			axis = 2'd2;
		end
		msum = {rd.lo[axis][COORD_W-1], rd.lo[axis]} + {rd.hi[axis][COORD_W-1], rd.hi[axis]};
		mid  = msum[MW-1:1];
		lo_half = rd;
		hi_half = rd;
		lo_half.hi[axis] = mid;
		hi_half.lo[axis] = mid;
		hit = 1'b1;
		for (int a = 0; a < 3; a++) begin
			if (!($signed(pt_q[a]) >= $signed(rd.lo[a]) && $signed(pt_q[a]) < $signed(rd.hi[a])))
			begin
				hit = 1'b0;
			end
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = i_q[AW-1:0];
		mem_wdata = rd;
		mem_raddr = i_q[AW-1:0];
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			S_INIT: begin
				mem_we         = (k_q != '0);
				mem_waddr      = '0;
				mem_wdata.lo   = wmin_q;
				mem_wdata.hi   = wmax_q;
			end
			S_SRD, S_SPL: mem_raddr = best_q[AW-1:0];
			S_SHR: mem_raddr = j_q[AW-1:0] - 1'b1;
			S_SHW: begin
				mem_we    = 1'b1;
				mem_waddr = j_q[AW-1:0];
			end
			S_WLO: begin
				mem_we    = 1'b1;
				mem_waddr = best_q[AW-1:0];
				mem_wdata = lowbox_q;
			end
			S_WHI: begin
				mem_we    = 1'b1;
				mem_waddr = best_nxt[AW-1:0];
				mem_wdata = highbox_q;
			end
			S_LCMP: mem_raddr = i_nxt[AW-1:0];
			S_M1: begin
				mul_a = mag_q[0];
				mul_b = mag_q[1];
			end
			S_M2: begin
				mul_a = prod[MW-1:0];
				mul_b = mag_q[2];
			end
			S_M3: begin
				mul_a = ph_q;
				mul_b = mag_q[2];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wmin_q      <= '0;
			wmax_q      <= '0;
			count_q     <= '0;
			built_q     <= '0;
			n_q         <= '0;
			k_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			best_q      <= '0;
			pt_q        <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			ph_q        <= '0;
			acc_q       <= '0;
			vol_q       <= '0;
			best_vol_q  <= '0;
			lowbox_q    <= '0;
			highbox_q   <= '0;
			box_q       <= '0;
			res_valid_q <= 1'b0;
			result_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MIN_X: wmin_q[0] <= cfg_data;
					REG_MIN_Y: wmin_q[1] <= cfg_data;
					REG_MIN_Z: wmin_q[2] <= cfg_data;
					REG_MAX_X: wmax_q[0] <= cfg_data;
					REG_MAX_Y: wmax_q[1] <= cfg_data;
					REG_MAX_Z: wmax_q[2] <= cfg_data;
					REG_COUNT: count_q   <= cfg_data[CNT_REG_W-1:0];
					default: begin
					end
				endcase
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						pt_q <= {item.point_z, item.point_y, item.point_x};
						i_q  <= '0;
						k_q  <= k_sat;
						if (item.op == OP_BUILD) begin
							state_q <= S_INIT;
						end else if (built_q == '0) begin
							state_q <= S_NF;
						end else begin
							state_q <= S_LRD;
						end
					end
				end
				S_INIT: begin
					if (k_q == '0) begin
						built_q <= '0;
						state_q <= S_NF;
					end else begin
						n_q     <= CNTW'(1);
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					i_q <= '0;
					if (n_q == k_q) begin
						built_q <= n_q;
						state_q <= S_ERD;
					end else begin
						state_q <= S_VRD;
					end
				end
				S_VRD: state_q <= S_VEXT;
				S_VEXT: begin
					mag_q   <= mag;
					neg_q   <= ext[0][MW-1] ^ ext[1][MW-1] ^ ext[2][MW-1];
					state_q <= S_M1;
				end
				S_M1: state_q <= S_M2;
				S_M2: begin
					ph_q    <= prod[PW-1:MW];
					state_q <= S_M3;
				end
				S_M3: begin
					acc_q   <= {{MW{1'b0}}, prod};
					state_q <= S_M4;
				end
				S_M4: begin
					acc_q   <= acc_q + {prod, {MW{1'b0}}};
					state_q <= S_SGN;
				end
				S_SGN: begin
					vol_q   <= neg_q ? (~{1'b0, acc_q} + 1'b1) : {1'b0, acc_q};
					state_q <= S_VCMP;
				end
				S_VCMP: begin
					if (i_q == '0 || $signed(vol_q) > $signed(best_vol_q)) begin
						best_vol_q <= vol_q;
						best_q     <= i_q;
					end
					if (i_nxt == n_q) begin
						state_q <= S_SRD;
					end else begin
						i_q     <= i_nxt;
						state_q <= S_VRD;
					end
				end
				S_SRD: state_q <= S_SPL;
				S_SPL: begin
					lowbox_q  <= lo_half;
					highbox_q <= hi_half;
					j_q       <= n_q;
					if (n_q > best_nxt) begin
						state_q <= S_SHR;
					end else begin
						state_q <= S_WLO;
					end
				end
				S_SHR: state_q <= S_SHW;
				S_SHW: begin
					j_q <= CNTW'(j_q - 1'b1);
					if (CNTW'(j_q - 1'b1) > best_nxt) begin
						state_q <= S_SHR;
					end else begin
						state_q <= S_WLO;
					end
				end
				S_WLO: state_q <= S_WHI;
				S_WHI: begin
					n_q     <= CNTW'(n_q + 1'b1);
					state_q <= S_CHK;
				end
				S_ERD: state_q <= S_EOUT;
				S_EOUT: begin
					if (room) begin
						result_q.cell_index <= IDX_OUT_W'(i_q);
						result_q.found      <= 1'b1;
						result_q.lo_x       <= rd.lo[0];
						result_q.lo_y       <= rd.lo[1];
						result_q.lo_z       <= rd.lo[2];
						result_q.hi_x       <= rd.hi[0];
						result_q.hi_y       <= rd.hi[1];
						result_q.hi_z       <= rd.hi[2];
						result_q.last       <= (i_nxt == n_q);
						if (i_nxt == n_q) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_nxt;
							state_q <= S_ERD;
						end
					end
				end
				S_LRD: state_q <= S_LCMP;
				S_LCMP: begin
					if (hit) begin
						box_q   <= rd;
						state_q <= S_LOUT;
					end else if (i_nxt == built_q) begin
						state_q <= S_NF;
					end else begin
						i_q <= i_nxt;
					end
				end
				S_LOUT: begin
					if (room) begin
						result_q.cell_index <= IDX_OUT_W'(i_q);
						result_q.found      <= 1'b1;
						result_q.lo_x       <= box_q.lo[0];
						result_q.lo_y       <= box_q.lo[1];
						result_q.lo_z       <= box_q.lo[2];
						result_q.hi_x       <= box_q.hi[0];
						result_q.hi_y       <= box_q.hi[1];
						result_q.hi_z       <= box_q.hi[2];
						result_q.last       <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				S_NF: begin
					if (room) begin
						result_q <= '{last: 1'b1, default: '0};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RCB_ASSERT_NOW(a_scan_in_range, clk, arst_n, state_q == S_VCMP, i_q < n_q,
		"volume scan index beyond cell count")
	`RCB_ASSERT_NOW(a_shift_above_split, clk, arst_n, state_q == S_SHW, j_q > best_nxt,
		"cell move would overwrite the split cell")
	`RCB_ASSERT_NOW(a_count_bounded, clk, arst_n, state_q == S_CHK,
		(n_q <= k_q) && (n_q != '0), "cell count out of range during build")
	`RCB_ASSERT_NEXT(a_emit_loads, clk, arst_n, (state_q == S_EOUT) && room,
		res_valid_q && result_q.found, "cell beat not loaded into the result register")

endmodule
